@@ rtl/sbs_pkg.sv @@
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared types and codes for the searchable bounded stack.
// ----------------------------------------------------------------------------
package sbs_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;
  localparam logic [1:0] CMD_SHOW   = 2'd3;

  localparam logic [2:0] ST_PUSHED    = 3'd0;
  localparam logic [2:0] ST_OVERFLOW  = 3'd1;
  localparam logic [2:0] ST_POPPED    = 3'd2;
  localparam logic [2:0] ST_UNDERFLOW = 3'd3;
  localparam logic [2:0] ST_FOUND     = 3'd4;
  localparam logic [2:0] ST_NOTFOUND  = 3'd5;
  localparam logic [2:0] ST_EMPTY     = 3'd6;
  localparam logic [2:0] ST_SHOWN     = 3'd7;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP,
    OP_ROT
  } sbs_op_e;

  typedef struct packed {
    sbs_op_e                   op;
    logic                      cmp_en;
    logic signed [DATA_W-1:0]  key;
  } sbs_ctrl_t;

  typedef struct packed {
    logic [1:0]                command;
    logic signed [DATA_W-1:0]  value;
  } sbs_in_t;

  typedef struct packed {
    logic [2:0]                status;
    logic signed [DATA_W-1:0]  data;
    logic                      last;
  } sbs_out_t;

endpackage

@@ rtl/sbs_cell.sv @@
// ----------------------------------------------------------------------------
// sbs_cell
// One stack slot: shifts with its neighbors and compares against a key.
// ----------------------------------------------------------------------------
module sbs_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sbs_pkg::sbs_ctrl_t                ctrl_i,
  input  logic                              active_i,
  input  logic                              is_end_i,
  input  logic signed [sbs_pkg::DATA_W-1:0] prev_i,
  input  logic signed [sbs_pkg::DATA_W-1:0] next_i,
  input  logic signed [sbs_pkg::DATA_W-1:0] wrap_i,
  output logic signed [sbs_pkg::DATA_W-1:0] data_o,
  output logic                              match_o
);

  logic signed [sbs_pkg::DATA_W-1:0] data_d, data_q;
  logic                              match_d, match_q;

  always_comb begin
    case (ctrl_i.op)
      sbs_pkg::OP_PUSH: data_d = prev_i;
      sbs_pkg::OP_POP:  data_d = next_i;
      sbs_pkg::OP_ROT:  data_d = is_end_i ? wrap_i : next_i;
      default:          data_d = data_q;
    endcase
    match_d = ctrl_i.cmp_en & active_i & (data_q == ctrl_i.key);
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

@@ rtl/searchable_bounded_stack.sv @@
// ----------------------------------------------------------------------------
// searchable_bounded_stack
// Bounded LIFO of signed words with search and full listing.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   item_i carries the command and the value. Every result appears on
//   result_o for one cycle with valid_o high; the receiver cannot stall.
//   The stack is a row of cells, top in cell 0; push and pop shift the row.
// Timing and throughput:
//   Push and pop: result in the cycle after the transaction, busy stays low,
//   so one transaction per cycle.
//   Search: the cells register their compare and the result is registered
//   from it; busy is high for one cycle.
//   Show: the row rotates once per cycle, one entry out per cycle; results
//   are registered after the show state; busy holds until the last entry.
//   Search and show on an empty stack answer like push and pop.
// Reset:
//   Clears the count and the control state; cell contents are undefined
//   and never read before they are written.
// ----------------------------------------------------------------------------
module searchable_bounded_stack #(
  parameter int unsigned DEPTH = sbs_pkg::DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  sbs_pkg::sbs_in_t item_i,
  output logic             valid_o,
  output sbs_pkg::sbs_out_t result_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_SHOW = 2'd2;

  logic [1:0]         state_d, state_q;
  logic [CNT_W-1:0]   count_d, count_q;
  logic [CNT_W-1:0]   show_d, show_q;
  logic               valid_d, valid_q;
  sbs_pkg::sbs_out_t  res_d, res_q;
  sbs_pkg::sbs_ctrl_t ctrl;
  logic               accept;
  logic               show_last;

  logic signed [sbs_pkg::DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]                  match;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [sbs_pkg::DATA_W-1:0] prev_w, next_w;
    if (i == 0) begin : g_top
      assign prev_w = item_i.value;
    end else begin : g_mid
      assign prev_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_bot
      assign next_w = '0;
    end else begin : g_nxt
      assign next_w = cell_data[i+1];
    end

    sbs_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .active_i (CNT_W'(i) < count_q),
      .is_end_i (count_q == CNT_W'(i + 1)),
      .prev_i   (prev_w),
      .next_i   (next_w),
      .wrap_i   (cell_data[0]),
      .data_o   (cell_data[i]),
      .match_o  (match[i])
    );
  end

  assign accept    = start & ~busy;
  assign show_last = (show_q == count_q - CNT_W'(1));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    show_d      = show_q;
    valid_d     = 1'b0;
    res_d       = res_q;
    ctrl.op     = sbs_pkg::OP_HOLD;
    ctrl.cmp_en = 1'b0;
    ctrl.key    = item_i.value;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d.data = '0;
          res_d.last = 1'b1;
          unique case (item_i.command)
            sbs_pkg::CMD_PUSH: begin
              valid_d = 1'b1;
              if (count_q == CNT_W'(DEPTH)) begin
                res_d.status = sbs_pkg::ST_OVERFLOW;
              end else begin
                res_d.status = sbs_pkg::ST_PUSHED;
                ctrl.op      = sbs_pkg::OP_PUSH;
                count_d      = count_q + CNT_W'(1);
              end
            end
            sbs_pkg::CMD_POP: begin
              valid_d = 1'b1;
              if (count_q == '0) begin
                res_d.status = sbs_pkg::ST_UNDERFLOW;
              end else begin
                res_d.status = sbs_pkg::ST_POPPED;
                res_d.data   = cell_data[0];
                ctrl.op      = sbs_pkg::OP_POP;
                count_d      = count_q - CNT_W'(1);
              end
            end
            sbs_pkg::CMD_SEARCH: begin
              if (count_q == '0) begin
                valid_d      = 1'b1;
                res_d.status = sbs_pkg::ST_EMPTY;
              end else begin
                ctrl.cmp_en = 1'b1;
                state_d     = S_SRCH;
              end
            end
            default: begin
              if (count_q == '0) begin
                valid_d      = 1'b1;
                res_d.status = sbs_pkg::ST_EMPTY;
              end else begin
                show_d  = '0;
                state_d = S_SHOW;
              end
            end
          endcase
        end
      end
      S_SRCH: begin
        valid_d      = 1'b1;
        res_d.status = (|match) ? sbs_pkg::ST_FOUND : sbs_pkg::ST_NOTFOUND;
        res_d.data   = '0;
        res_d.last   = 1'b1;
        state_d      = S_IDLE;
      end
      S_SHOW: begin
        valid_d      = 1'b1;
        res_d.status = sbs_pkg::ST_SHOWN;
        res_d.data   = cell_data[0];
        res_d.last   = show_last;
        ctrl.op      = sbs_pkg::OP_ROT;
        show_d       = show_q + CNT_W'(1);
        if (show_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      show_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      show_q  <= show_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule
